>>> rtl/serial_decimal_to_led_bar_defines.svh
// Assertion macros shared by the serial decimal to LED bar RTL.
`ifndef SERIAL_DECIMAL_TO_LED_BAR_DEFINES_SVH
`define SERIAL_DECIMAL_TO_LED_BAR_DEFINES_SVH

`ifndef SYNTHESIS
// Checked on every clock edge outside reset.
`define SDLB_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("sdlb: assertion failed");
// Checked on every clock edge, reset included.
`define SDLB_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge clk) (prop)) \
    else $error("sdlb: assertion failed");
`else
`define SDLB_ASSERT(label, prop)
`define SDLB_ASSERT_ALWAYS(label, prop)
`endif

`endif

>>> rtl/sdlb_pkg.sv
// Types, constants and helper functions for the serial decimal to LED bar block.
package sdlb_pkg;

    localparam int MAX_LINE_CHARS = 14;
    localparam int COUNT_W        = $clog2(MAX_LINE_CHARS + 1);

    localparam int BYTE_W   = 8;
    localparam int LIMIT_W  = 8;
    localparam int LEVEL_W  = 3;
    localparam int LED_W    = 4;
    localparam int CFG_IDX_W = 3;

    localparam logic [BYTE_W-1:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [BYTE_W-1:0] CHAR_MINUS   = 8'h2D;
    localparam logic [BYTE_W-1:0] CHAR_DOT     = 8'h2E;
    localparam logic [BYTE_W-1:0] CHAR_ZERO    = 8'h30;
    localparam logic [BYTE_W-1:0] CHAR_NINE    = 8'h39;

    localparam logic [LIMIT_W-1:0] FAR_RESET   = 8'd10;
    localparam logic [LIMIT_W-1:0] MID_RESET   = 8'd8;
    localparam logic [LIMIT_W-1:0] NEAR_RESET  = 8'd6;
    localparam logic [LIMIT_W-1:0] CLOSE_RESET = 8'd4;
    localparam logic [LIMIT_W-1:0] HELD_RESET  = 8'd100;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FAR_LIMIT   = 3'd0,
        REG_MID_LIMIT   = 3'd1,
        REG_NEAR_LIMIT  = 3'd2,
        REG_CLOSE_LIMIT = 3'd3
    } cfg_reg_t;

    typedef enum logic [LEVEL_W-1:0] {
        LVL_FAR     = 3'd0,
        LVL_MID     = 3'd1,
        LVL_NEAR    = 3'd2,
        LVL_CLOSE   = 3'd3,
        LVL_CLOSEST = 3'd4
    } level_t;

    // Line accumulator
    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [7:0]         int_part;
        logic               frac_nz;
        logic               in_frac;
        logic               negative;
        logic               stopped;
    } acc_t;

    // Committed distance
    typedef struct packed {
        logic [7:0] int_part;
        logic       frac_nz;
        logic       negative;
    } held_t;

    typedef struct packed {
        logic [LIMIT_W-1:0] far_lim;
        logic [LIMIT_W-1:0] mid_lim;
        logic [LIMIT_W-1:0] near_lim;
        logic [LIMIT_W-1:0] close_lim;
    } limits_t;

    // Negative zero counts as non-negative.
    function automatic logic held_nonneg(held_t h);
        return !h.negative || (h.int_part == 8'd0 && !h.frac_nz);
    endfunction

    function automatic logic held_gt(held_t h, logic [LIMIT_W-1:0] lim);
        return held_nonneg(h) &&
               ((h.int_part > lim) || (h.int_part == lim && h.frac_nz));
    endfunction

    function automatic logic held_ge(held_t h, logic [LIMIT_W-1:0] lim);
        return held_nonneg(h) && (h.int_part >= lim);
    endfunction

    function automatic level_t level_of(held_t h, limits_t l);
        level_t lv;
        lv = LVL_FAR;
        priority if (held_gt(h, l.far_lim))
            lv = LVL_FAR;
        else if (held_ge(h, l.mid_lim) && !held_gt(h, l.far_lim))
            lv = LVL_MID;
        else if (held_ge(h, l.near_lim) && !held_ge(h, l.mid_lim))
            lv = LVL_NEAR;
        else if (held_ge(h, l.close_lim) && !held_ge(h, l.near_lim))
            lv = LVL_CLOSE;
        else if (!held_ge(h, l.close_lim))
            lv = LVL_CLOSEST;
        else
            lv = LVL_FAR;
        return lv;
    endfunction

    // Lowest lv bits set
    function automatic logic [LED_W-1:0] thermo(logic [LEVEL_W-1:0] lv);
        logic [LED_W:0] t;
        t = (LED_W+1)'(((LED_W+1)'(1) << lv) - (LED_W+1)'(1));
        return t[LED_W-1:0];
    endfunction

endpackage

>>> rtl/serial_decimal_to_led_bar.sv
// Serial decimal line parser driving a proximity level and a thermometer LED bar.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-------------------------------
//  rx      | in        | rx_valid / rx_stall    | rx_byte[7:0]
//  res     | out       | res_valid / res_stall  | level[2:0], led_bar[3:0], line_end
//  cfg     | in        | cfg_valid / cfg_ready  | cfg_index[2:0], cfg_data[7:0]
//
// One item per cycle while rx_stall is low. A byte is parsed and its result
// registered in the cycle it is accepted, so the result appears in the next cycle.
// rx_stall rises only while a registered result is waiting and res_stall is
// high; a taken result and a new item may pass in the same cycle.
// cfg_ready is always high. Reset (rst_n, asynchronous) restores the default
// limits, an empty line and a held distance of 100.
module serial_decimal_to_led_bar (
    input  logic                          clk,
    input  logic                          rst_n,
    // received bytes
    input  logic                          rx_valid,
    output logic                          rx_stall,
    input  logic [sdlb_pkg::BYTE_W-1:0]   rx_byte,
    // results
    output logic                          res_valid,
    input  logic                          res_stall,
    output logic [sdlb_pkg::LEVEL_W-1:0]  level,
    output logic [sdlb_pkg::LED_W-1:0]    led_bar,
    output logic                          line_end,
    // configuration writes
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [sdlb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sdlb_pkg::LIMIT_W-1:0]  cfg_data
);
    import sdlb_pkg::*;

`include "serial_decimal_to_led_bar_defines.svh"

    limits_t              limits_reg;
    acc_t                 acc_reg, acc_next;
    held_t                held_reg, held_next;
    logic                 res_valid_reg, res_valid_next;
    logic [LEVEL_W-1:0]   level_reg;
    logic [LED_W-1:0]     led_bar_reg;
    logic                 line_end_reg;

    logic                 accept;
    logic                 is_newline;
    logic                 is_digit;
    logic [3:0]           digit;
    logic [11:0]          scaled;
    level_t               level_next;

    assign cfg_ready = 1'b1;
    assign rx_stall  = res_valid_reg && res_stall;
    assign accept    = rx_valid && !rx_stall;

    assign is_newline = (rx_byte == CHAR_NEWLINE);
    assign is_digit   = (rx_byte >= CHAR_ZERO) && (rx_byte <= CHAR_NINE);
    assign digit      = rx_byte[3:0];
    // acc * 10 + digit; tops out at 2559, well inside 12 bits
    assign scaled     = ({4'd0, acc_reg.int_part} << 3) + ({4'd0, acc_reg.int_part} << 1)
                      + {8'd0, digit};

    // Parser: a newline commits and clears; other bytes fill up to the line limit.
    always_comb
    begin
        acc_next  = acc_reg;
        held_next = held_reg;
        if (is_newline)
        begin
            held_next.int_part = acc_reg.int_part;
            held_next.frac_nz  = acc_reg.frac_nz;
            held_next.negative = acc_reg.negative;
            acc_next           = '0;
        end
        else if (acc_reg.count < COUNT_W'(MAX_LINE_CHARS))
        begin
            acc_next.count = acc_reg.count + COUNT_W'(1);
            // leading minus is a sign; anywhere else it stops parsing
            if (acc_reg.count == '0 && rx_byte == CHAR_MINUS)
                acc_next.negative = 1'b1;
            else if (!acc_reg.stopped)
            begin
                if (rx_byte == CHAR_DOT)
                    acc_next.in_frac = 1'b1;
                else if (is_digit)
                begin
                    if (acc_reg.in_frac)
                        acc_next.frac_nz = acc_reg.frac_nz || (digit != 4'd0);
                    else
                        acc_next.int_part = (scaled > 12'd255) ? 8'hFF : scaled[7:0];
                end
                else
                    acc_next.stopped = 1'b1;
            end
        end
    end

    assign level_next = level_of(held_next, limits_reg);

    always_comb
    begin
        if (accept)
            res_valid_next = 1'b1;
        else if (res_stall)
            res_valid_next = res_valid_reg;
        else
            res_valid_next = 1'b0;
    end

    // Control state and limits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limits_reg.far_lim   <= FAR_RESET;
            limits_reg.mid_lim   <= MID_RESET;
            limits_reg.near_lim  <= NEAR_RESET;
            limits_reg.close_lim <= CLOSE_RESET;
            acc_reg              <= '0;
            held_reg.int_part    <= HELD_RESET;
            held_reg.frac_nz     <= 1'b0;
            held_reg.negative    <= 1'b0;
            res_valid_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_FAR_LIMIT:   limits_reg.far_lim   <= cfg_data;
                    REG_MID_LIMIT:   limits_reg.mid_lim   <= cfg_data;
                    REG_NEAR_LIMIT:  limits_reg.near_lim  <= cfg_data;
                    REG_CLOSE_LIMIT: limits_reg.close_lim <= cfg_data;
                    default:         ; // unmapped index: write dropped
                endcase
            end
            if (accept)
            begin
                acc_reg  <= acc_next;
                held_reg <= held_next;
            end
            res_valid_reg <= res_valid_next;
        end
    end

    // Result register, loaded with each accepted item
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            level_reg    <= level_next;
            led_bar_reg  <= thermo(level_next);
            line_end_reg <= is_newline;
        end
    end

    assign res_valid = res_valid_reg;
    assign level     = level_reg;
    assign led_bar   = led_bar_reg;
    assign line_end  = line_end_reg;

    // A newline empties the line and is flagged on its result.
    `SDLB_ASSERT(a_newline_clears, (accept && is_newline) |=> (acc_reg == '0 && line_end_reg && res_valid_reg))
    // Other bytes never raise line_end.
    `SDLB_ASSERT(a_no_false_end, (accept && !is_newline) |=> !line_end_reg)
    // Kept-byte count never passes the line limit.
    `SDLB_ASSERT(a_count_bound, acc_reg.count <= COUNT_W'(MAX_LINE_CHARS))
    // The LED pattern always matches the level it carries.
    `SDLB_ASSERT(a_bar_matches, res_valid_reg |-> (led_bar_reg == thermo(level_reg) && level_reg <= LEVEL_W'(LVL_CLOSEST)))

endmodule

>>> dv/testbench.sv
// Self-checking testbench for the serial decimal to LED bar block.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import sdlb_pkg::*;

    // ------------------------------------------------------------------
    // Run shape
    // ------------------------------------------------------------------
    localparam int NUM_LIMITS   = 4;       // registers 0..3; higher indexes are ignored
    localparam int PHASE_ITEMS  = 125;     // minimum random bytes per limit setting
    localparam int NUM_PHASES   = 6;
    localparam int HOLD_AFTER   = 300;     // results seen before the long receiver hold
    localparam int HOLD_CYCLES  = 60;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int N_OPEN       = 25;

    // One result item: level, LED pattern and the commit flag
    typedef struct packed {
        level_t         lvl;
        logic [LED_W-1:0] leds;
        logic           ended;
    } bar_t;

    // One row of the opening sequence; typed rows carry a hand-written expectation
    typedef struct packed {
        logic [BYTE_W-1:0] ch;
        logic              typed;
        bar_t              want;
    } row_t;

    localparam bar_t NO_BAR = '{LVL_FAR, 4'h0, 1'b0};

    // ------------------------------------------------------------------
    // DUT signals
    // ------------------------------------------------------------------
    logic                 clk;
    logic                 rst_n;
    logic                 rx_valid;
    logic                 rx_stall;
    logic [BYTE_W-1:0]    rx_byte;
    logic                 res_valid;
    logic                 res_stall;
    logic [LEVEL_W-1:0]   level;
    logic [LED_W-1:0]     led_bar;
    logic                 line_end;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [LIMIT_W-1:0]   cfg_data;

    serial_decimal_to_led_bar u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx_valid  (rx_valid),
        .rx_stall  (rx_stall),
        .rx_byte   (rx_byte),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .level     (level),
        .led_bar   (led_bar),
        .line_end  (line_end),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------
    // Opening sequence, run under the reset limits (far 10, mid 8, near 6,
    // close 4) with a held distance of 100 straight out of reset.
    // Only the easy-to-read rows carry a typed expectation.
    // ------------------------------------------------------------------
    row_t opening [N_OPEN] = '{
        // first byte after reset: held 100 is beyond far, nothing lit
        '{CHAR_ZERO + 8'd5, 1'b1, '{LVL_FAR,     4'h0, 1'b0}},
        // "5" committed: between close and near
        '{CHAR_NEWLINE,     1'b1, '{LVL_CLOSE,   4'h7, 1'b1}},
        // "-7": a negative distance lights everything
        '{CHAR_MINUS,       1'b0, NO_BAR},
        '{CHAR_ZERO + 8'd7, 1'b0, NO_BAR},
        '{CHAR_NEWLINE,     1'b1, '{LVL_CLOSEST, 4'hF, 1'b1}},
        // lone minus sign reads as zero
        '{CHAR_MINUS,       1'b0, NO_BAR},
        '{CHAR_NEWLINE,     1'b1, '{LVL_CLOSEST, 4'hF, 1'b1}},
        // empty line commits zero
        '{CHAR_NEWLINE,     1'b1, '{LVL_CLOSEST, 4'hF, 1'b1}},
        // "10..5": second dot is harmless, the 5 makes it just beyond far
        '{CHAR_ZERO + 8'd1, 1'b0, NO_BAR},
        '{CHAR_ZERO,        1'b0, NO_BAR},
        '{CHAR_DOT,         1'b0, NO_BAR},
        '{CHAR_DOT,         1'b0, NO_BAR},
        '{CHAR_ZERO + 8'd5, 1'b0, NO_BAR},
        '{CHAR_NEWLINE,     1'b1, '{LVL_FAR,     4'h0, 1'b1}},
        // "999" saturates at 255
        '{CHAR_ZERO + 8'd9, 1'b0, NO_BAR},
        '{CHAR_ZERO + 8'd9, 1'b0, NO_BAR},
        '{CHAR_ZERO + 8'd9, 1'b0, NO_BAR},
        '{CHAR_NEWLINE,     1'b1, '{LVL_FAR,     4'h0, 1'b1}},
        // byte extremes: both stop the parse, line reads as zero
        '{8'h00,            1'b0, NO_BAR},
        '{8'hFF,            1'b0, NO_BAR},
        '{CHAR_NEWLINE,     1'b1, '{LVL_CLOSEST, 4'hF, 1'b1}},
        // minus in mid-line stops the parse: "1-8" is 1
        '{CHAR_ZERO + 8'd1, 1'b0, NO_BAR},
        '{CHAR_MINUS,       1'b0, NO_BAR},
        '{CHAR_ZERO + 8'd8, 1'b0, NO_BAR},
        '{CHAR_NEWLINE,     1'b1, '{LVL_CLOSEST, 4'hF, 1'b1}}
    };

    // ------------------------------------------------------------------
    // Predictor state: the line being parsed, the committed distance and
    // the limits as last written.
    // ------------------------------------------------------------------
    logic [COUNT_W-1:0] line_len     = '0;
    logic [7:0]         part_int     = '0;
    logic               part_frac_nz = 1'b0;
    logic               part_in_frac = 1'b0;
    logic               part_neg     = 1'b0;
    logic               part_done    = 1'b0;
    logic [7:0]         dist_int     = HELD_RESET;
    logic               dist_frac_nz = 1'b0;
    logic               dist_neg     = 1'b0;
    logic [7:0]         lim_far      = FAR_RESET;
    logic [7:0]         lim_mid      = MID_RESET;
    logic [7:0]         lim_near     = NEAR_RESET;
    logic [7:0]         lim_close    = CLOSE_RESET;

    bar_t              pending_bars [$];   // results still owed by the block
    logic [BYTE_W-1:0] line_buf [$];       // bytes of the line being sent
    int                errors;
    int                bars_seen;
    int                cycles;
    bit                quiet;              // no idling on either side
    bit                long_hold_done;

    // Side-band of the item on the rx port: a hand-typed expectation, if any
    logic row_typed;
    bar_t row_want;

    // Advance the parser by one byte and rate the committed distance.
    function automatic bar_t parse_and_rate(input logic [BYTE_W-1:0] ch);
        bar_t       r;
        logic [11:0] grown;
        logic       nonneg, over_far, reach_mid, reach_near, reach_close;
        r.ended = 1'b0;
        if (ch == CHAR_NEWLINE)
        begin
            dist_int     = part_int;
            dist_frac_nz = part_frac_nz;
            dist_neg     = part_neg;
            line_len     = '0;
            part_int     = '0;
            part_frac_nz = 1'b0;
            part_in_frac = 1'b0;
            part_neg     = 1'b0;
            part_done    = 1'b0;
            r.ended      = 1'b1;
        end
        else if (line_len < MAX_LINE_CHARS)
        begin
            // a minus counts as a sign only as the first byte of the line
            if (line_len == 0 && ch == CHAR_MINUS)
                part_neg = 1'b1;
            else if (!part_done)
            begin
                if (ch == CHAR_DOT)
                    part_in_frac = 1'b1;
                else if (ch >= CHAR_ZERO && ch <= CHAR_NINE)
                begin
                    if (part_in_frac)
                        part_frac_nz = part_frac_nz | (ch != CHAR_ZERO);
                    else
                    begin
                        grown    = part_int * 12'd10 + (ch - CHAR_ZERO);
                        part_int = (grown > 12'd255) ? 8'd255 : grown[7:0];
                    end
                end
                else
                    part_done = 1'b1;
            end
            line_len = line_len + 1'b1;
        end

        // negative zero rates as zero
        nonneg      = !dist_neg || (dist_int == 8'd0 && !dist_frac_nz);
        over_far    = nonneg && (dist_int > lim_far || (dist_int == lim_far && dist_frac_nz));
        reach_mid   = nonneg && dist_int >= lim_mid;
        reach_near  = nonneg && dist_int >= lim_near;
        reach_close = nonneg && dist_int >= lim_close;
        if (over_far)
            r.lvl = LVL_FAR;
        else if (reach_mid)
            r.lvl = LVL_MID;
        else if (reach_near)
            r.lvl = LVL_NEAR;
        else if (reach_close)
            r.lvl = LVL_CLOSE;
        else
            r.lvl = LVL_CLOSEST;
        r.leds = ~(4'hF << r.lvl);
        return r;
    endfunction

    // Idle length: mostly none, some short, a few long
    function automatic int pick_idle();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 96)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Random line: mostly well-formed numbers near the current limits,
    // some with a stray byte, some pure noise, a few empty.
    function automatic void compose_line();
        int    kind, value, pos, i;
        string digits;
        logic [7:0] lim;
        line_buf.delete();
        kind = $urandom_range(0, 99);
        if (kind < 5)
        begin
            // empty line
        end
        else if (kind < 15)
        begin
            repeat ($urandom_range(1, 20))
                line_buf.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            if ($urandom_range(0, 4) == 0)
                line_buf.push_back(CHAR_MINUS);
            // leading zeros push some lines past the kept length
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(1, 14))
                    line_buf.push_back(CHAR_ZERO);
            case ($urandom_range(0, 3))
                0: lim = lim_far;
                1: lim = lim_mid;
                2: lim = lim_near;
                default: lim = lim_close;
            endcase
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: value = int'(lim) + $urandom_range(0, 2) - 1;
                5, 6, 7:       value = $urandom_range(0, 20);
                default:       value = $urandom_range(0, 999);
            endcase
            if (value < 0)
                value = 0;
            if ($urandom_range(0, 9) != 0)
            begin
                digits = $sformatf("%0d", value);
                for (i = 0; i < digits.len(); i++)
                    line_buf.push_back(digits[i]);
            end
            if ($urandom_range(0, 1) == 1)
            begin
                line_buf.push_back(CHAR_DOT);
                repeat ($urandom_range(0, 3))
                    line_buf.push_back($urandom_range(0, 1) ? CHAR_ZERO
                                                           : CHAR_ZERO + 8'($urandom_range(0, 9)));
                if ($urandom_range(0, 7) == 0)
                begin
                    line_buf.push_back(CHAR_DOT);
                    line_buf.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
                end
            end
            // broken number: a stray byte somewhere, often a minus
            if (kind < 30)
            begin
                pos = $urandom_range(0, line_buf.size());
                line_buf.insert(pos, $urandom_range(0, 1) ? CHAR_MINUS
                                                          : 8'($urandom_range(0, 255)));
            end
        end
        line_buf.push_back(CHAR_NEWLINE);
    endfunction

    // ------------------------------------------------------------------
    // Drivers. Everything changes on the falling edge; each task is entered
    // and left on a falling edge.
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [BYTE_W-1:0] ch, input logic typed, input bar_t want);
        int gap;
        gap = pick_idle();
        if (gap > 0)
        begin
            rx_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        rx_valid  <= 1'b1;
        rx_byte   <= ch;
        row_typed <= typed;
        row_want  <= want;
        do
            @(posedge clk);
        while (rx_stall);
        @(negedge clk);
    endtask

    task automatic write_limit(input logic [CFG_IDX_W-1:0] idx, input logic [LIMIT_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
    endtask

    // Stop offering and wait for every owed result
    task automatic drain();
        rx_valid <= 1'b0;
        while (pending_bars.size() != 0)
            @(negedge clk);
    endtask

    // Limits are only touched with the block idle, once every owed result has drained.
    task automatic load_limits(input logic [7:0] f, m, n, c, input bit stray);
        drain();
        repeat (3) @(negedge clk);
        write_limit(REG_FAR_LIMIT, f);
        write_limit(REG_MID_LIMIT, m);
        write_limit(REG_NEAR_LIMIT, n);
        write_limit(REG_CLOSE_LIMIT, c);
        // index past the last register: must be ignored
        if (stray)
            write_limit(CFG_IDX_W'(NUM_LIMITS + $urandom_range(0, 3)),
                        8'($urandom_range(0, 200)));
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stalls, plus one long hold once enough results have
    // gone by, so the block fills up and pushes back on rx.
    // ------------------------------------------------------------------
    initial
    begin
        int n;
        res_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!long_hold_done && bars_seen >= HOLD_AFTER)
            begin
                long_hold_done = 1'b1;
                res_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end
            else
            begin
                n = pick_idle();
                res_stall <= (n > 0);
                if (n > 1)
                    repeat (n - 1) @(negedge clk);
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: results are checked before the new item is predicted, so a
    // result can never be matched against its own item.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        bar_t want;
        bar_t model;
        if (rst_n)
        begin
            if (res_valid && !res_stall)
            begin
                if (pending_bars.size() == 0)
                begin
                    errors++;
                    $error("result item with nothing outstanding");
                end
                else
                begin
                    want = pending_bars.pop_front();
                    if (level !== want.lvl)
                    begin
                        errors++;
                        $error("level: expected %0d, got %0d", want.lvl, level);
                    end
                    if (led_bar !== want.leds)
                    begin
                        errors++;
                        $error("led_bar: expected %h, got %h", want.leds, led_bar);
                    end
                    if (line_end !== want.ended)
                    begin
                        errors++;
                        $error("line_end: expected %0d, got %0d", want.ended, line_end);
                    end
                end
                bars_seen++;
            end
            if (rx_valid && !rx_stall)
            begin
                model = parse_and_rate(rx_byte);
                pending_bars.push_back(row_typed ? row_want : model);
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_FAR_LIMIT:   lim_far   = cfg_data;
                    REG_MID_LIMIT:   lim_mid   = cfg_data;
                    REG_NEAR_LIMIT:  lim_near  = cfg_data;
                    REG_CLOSE_LIMIT: lim_close = cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        logic [7:0] f, m, n, c;
        int         phase, sent;
        rst_n     = 1'b0;
        rx_valid  = 1'b0;
        rx_byte   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        row_typed = 1'b0;
        row_want  = NO_BAR;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // opening sequence under reset limits
        foreach (opening[r])
            send_byte(opening[r].ch, opening[r].typed, opening[r].want);

        for (phase = 0; phase < NUM_PHASES; phase++)
        begin
            quiet = 1'b0;
            case (phase)
                0:  load_limits(8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
                1:  load_limits(8'd200, 8'd200, 8'd200, 8'd200, 1'b1);
                2, 4:
                begin
                    // sensible descending limits
                    f = 8'($urandom_range(3, 200));
                    m = 8'($urandom_range(0, f));
                    n = 8'($urandom_range(0, m));
                    c = 8'($urandom_range(0, n));
                    load_limits(f, m, n, c, phase == 4);
                    quiet = (phase == 4);   // a stretch with no idling at all
                end
                default:
                begin
                    // limits in any order
                    load_limits(8'($urandom_range(0, 200)), 8'($urandom_range(0, 200)),
                                8'($urandom_range(0, 200)), 8'($urandom_range(0, 200)), 1'b1);
                end
            endcase
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                compose_line();
                foreach (line_buf[k])
                begin
                    send_byte(line_buf[k], 1'b0, NO_BAR);
                    sent++;
                end
            end
        end

        drain();
        repeat (4) @(posedge clk);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl
rtl/sdlb_pkg.sv
rtl/serial_decimal_to_led_bar.sv
dv/testbench.sv
